// File: src/ssef_pkg.sv
// ----------------------------------------------------------------------------
// ssef_pkg: shared types and constants of the Sobel/Scharr edge filter
// Pixel and line geometry, configuration codes and the structs that pass
// between the line-store front end, the filter lanes and the output queue.
// ----------------------------------------------------------------------------
package ssef_pkg;

  // Geometry of one stream word and of the line stores.
  localparam int BYTES_PER_BEAT = 4;
  localparam int LINE_MAX       = 2048;
  localparam int PIX_W          = 8;
  localparam int WORD_W         = BYTES_PER_BEAT * PIX_W;
  localparam int KEEP_W         = 4;
  localparam int COL_W          = 12;
  localparam int PIX_SHIFT      = $clog2(BYTES_PER_BEAT);
  localparam int ROWS           = LINE_MAX / BYTES_PER_BEAT;
  localparam int ROW_W          = $clog2(ROWS);

  // Gradient arithmetic width: worst case |Gx| is 3*510 + 10*255 = 4080.
  localparam int GRAD_W         = 14;
  localparam logic [PIX_W-1:0] MAG_MAX = 8'd255;

  // Output queue depth: covers the pipeline latency for a word per cycle.
  localparam int FIFO_DEPTH     = 8;
  localparam int FIFO_PTR_W     = $clog2(FIFO_DEPTH);
  localparam int OCC_W          = $clog2(FIFO_DEPTH + 1);

  // Configuration register file.
  localparam logic [COL_W-1:0] LINE_WIDTH_RESET = 12'd1920;

  typedef enum logic [0:0] {
    CFG_LINE_WIDTH    = 1'b0,
    CFG_KERNEL_SELECT = 1'b1
  } cfg_index_e;

  typedef enum logic [0:0] {
    KERNEL_SOBEL  = 1'b0,
    KERNEL_SCHARR = 1'b1
  } kernel_e;

  // One window column: older line, newer line, current line.
  typedef struct packed {
    logic [PIX_W-1:0] older;
    logic [PIX_W-1:0] newer;
    logic [PIX_W-1:0] current;
  } col3_t;

  // One row of both line stores, covering the pixels of one word.
  typedef struct packed {
    logic [BYTES_PER_BEAT-1:0][PIX_W-1:0] older;
    logic [BYTES_PER_BEAT-1:0][PIX_W-1:0] newer;
  } line_row_t;

  // Side information that travels along with a word.
  typedef struct packed {
    logic [KEEP_W-1:0] keep;
    logic [KEEP_W-1:0] strb;
    logic              last;
    logic              clamped;
  } side_t;

  // One finished output word.
  typedef struct packed {
    logic [BYTES_PER_BEAT-1:0][PIX_W-1:0] pixels;
    side_t                                side;
  } out_word_t;

endpackage

// File: src/ssef_ram.sv
// ----------------------------------------------------------------------------
// ssef_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module ssef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; returns the old data on a same-address write.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: src/ssef_lane.sv
// ----------------------------------------------------------------------------
// ssef_lane: one 3x3 gradient lane
// Applies the Sobel or Scharr Gx and Gy kernels to one window and returns
// min(|Gx| + |Gy|, 255). Two register stages: gradients, then magnitude.
// ----------------------------------------------------------------------------
module ssef_lane (
  input  logic                            clk_i,
  input  ssef_pkg::kernel_e               kernel_i,
  input  ssef_pkg::col3_t [2:0]           win_i,
  output logic [ssef_pkg::PIX_W-1:0]      mag_o
);

  logic signed [ssef_pkg::GRAD_W-1:0] dx_top, dx_mid, dx_bot;
  logic signed [ssef_pkg::GRAD_W-1:0] dy_left, dy_mid, dy_right;
  logic signed [ssef_pkg::GRAD_W-1:0] gx_outer, gx_inner, gy_outer, gy_inner;
  logic signed [ssef_pkg::GRAD_W-1:0] gx_d, gy_d, gx_q, gy_q;
  logic signed [ssef_pkg::GRAD_W-1:0] abs_x, abs_y;
  logic        [ssef_pkg::GRAD_W-1:0] sum;
  logic        [ssef_pkg::PIX_W-1:0]  mag_d;

  function automatic logic signed [ssef_pkg::GRAD_W-1:0] ext(
    input logic [ssef_pkg::PIX_W-1:0] p
  );
    ext = signed'({{(ssef_pkg::GRAD_W - ssef_pkg::PIX_W){1'b0}}, p});
  endfunction

  // Row differences (left minus right) and column differences (top minus bottom).
  always_comb begin
    dx_top   = ext(win_i[0].older)   - ext(win_i[2].older);
    dx_mid   = ext(win_i[0].newer)   - ext(win_i[2].newer);
    dx_bot   = ext(win_i[0].current) - ext(win_i[2].current);
    dy_left  = ext(win_i[0].older)   - ext(win_i[0].current);
    dy_mid   = ext(win_i[1].older)   - ext(win_i[1].current);
    dy_right = ext(win_i[2].older)   - ext(win_i[2].current);
  end

  // Weights: outer 1 and inner 2 for Sobel, outer 3 and inner 10 for Scharr.
  always_comb begin
    gx_outer = dx_top + dx_bot;
    gy_outer = dy_left + dy_right;
    case (kernel_i)
      ssef_pkg::KERNEL_SOBEL: begin
        gx_inner = dx_mid <<< 1;
        gy_inner = dy_mid <<< 1;
      end
      ssef_pkg::KERNEL_SCHARR: begin
        gx_outer = (gx_outer <<< 1) + gx_outer;
        gy_outer = (gy_outer <<< 1) + gy_outer;
        gx_inner = (dx_mid <<< 3) + (dx_mid <<< 1);
        gy_inner = (dy_mid <<< 3) + (dy_mid <<< 1);
      end
      default: begin
        gx_inner = dx_mid <<< 1;
        gy_inner = dy_mid <<< 1;
      end
    endcase
    gx_d = gx_outer + gx_inner;
    gy_d = gy_outer + gy_inner;
  end

  // Gradient stage.
  always_ff @(posedge clk_i) begin
    gx_q <= gx_d;
    gy_q <= gy_d;
  end

  // Magnitude with saturation.
  always_comb begin
    abs_x = gx_q[ssef_pkg::GRAD_W-1] ? -gx_q : gx_q;
    abs_y = gy_q[ssef_pkg::GRAD_W-1] ? -gy_q : gy_q;
    sum   = unsigned'(abs_x) + unsigned'(abs_y);
    if (sum > {{(ssef_pkg::GRAD_W - ssef_pkg::PIX_W){1'b0}}, ssef_pkg::MAG_MAX}) begin
      mag_d = ssef_pkg::MAG_MAX;
    end else begin
      mag_d = sum[ssef_pkg::PIX_W-1:0];
    end
  end

  // Magnitude stage.
  always_ff @(posedge clk_i) begin
    mag_o <= mag_d;
  end

endmodule

// File: src/ssef_out_fifo.sv
// ----------------------------------------------------------------------------
// ssef_out_fifo: merge of lane results and output queue
// Packs the lane magnitudes with the side information into one word and
// holds finished words until the downstream side takes them.
// ----------------------------------------------------------------------------
module ssef_out_fifo (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  push_i,
  input  logic [ssef_pkg::BYTES_PER_BEAT-1:0][ssef_pkg::PIX_W-1:0] mags_i,
  input  ssef_pkg::side_t                                       side_i,
  output logic                                                  valid_o,
  input  logic                                                  ready_i,
  output ssef_pkg::out_word_t                                   word_o
);

  ssef_pkg::out_word_t                mem_q [ssef_pkg::FIFO_DEPTH];
  logic [ssef_pkg::FIFO_PTR_W-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [ssef_pkg::OCC_W-1:0]         cnt_q, cnt_d;
  logic                               pop;

  assign valid_o = (cnt_q != '0);
  assign pop     = valid_o && ready_i;
  assign word_o  = mem_q[rptr_q];

  // Pointer and fill count update; the producer never overruns the queue.
  always_comb begin
    wptr_d = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop    ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage of merged words.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= '{pixels: mags_i, side: side_i};
    end
  end

endmodule

// File: src/sobel_scharr_edge_filter.sv
// ----------------------------------------------------------------------------
// sobel_scharr_edge_filter: 3x3 Sobel/Scharr edge magnitude on a pixel stream
// Keeps two previous lines and a sliding 3x3 window, filters the four
// pixels of each word in parallel lanes and emits saturated magnitudes.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  in        sink       in_valid/in_ready    pixels, keep, strb, last
//  out       source     out_valid/out_ready  pixels, keep, strb, last, width_clamped
//  cfg       sink       cfg_we (no wait)     index, data
//
// One word is accepted per cycle while in_ready is high; its result passes the
// line-store read at the accepting edge, then the gradient stage, the magnitude
// stage and the queue write before it reaches the output.
// After reset a clearing pass zeroes the line stores, one row of four pixels
// per cycle, until all 512 rows are cleared; no word is taken during that pass.
// An output stall is absorbed by an 8-word queue; in_ready drops only during the
// clearing pass or when eight words are in flight or waiting.
//
module sobel_scharr_edge_filter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration.
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [ssef_pkg::COL_W-1:0]    cfg_data_i,
  // Input words.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ssef_pkg::WORD_W-1:0]   in_pixels_i,
  input  logic [ssef_pkg::KEEP_W-1:0]   in_keep_i,
  input  logic [ssef_pkg::KEEP_W-1:0]   in_strb_i,
  input  logic                          in_last_i,
  // Output words.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ssef_pkg::WORD_W-1:0]   out_pixels_o,
  output logic [ssef_pkg::KEEP_W-1:0]   out_keep_o,
  output logic [ssef_pkg::KEEP_W-1:0]   out_strb_o,
  output logic                          out_last_o,
  output logic                          width_clamped_o
);

  localparam int BPB = ssef_pkg::BYTES_PER_BEAT;

  // Configuration registers.
  logic [ssef_pkg::COL_W-1:0] line_width_q, line_width_d;
  ssef_pkg::kernel_e          kernel_q, kernel_d;

  // Clearing pass.
  logic                       clr_q, clr_d;
  logic [ssef_pkg::ROW_W-1:0] clr_cnt_q, clr_cnt_d;

  // Column position and occupancy.
  logic [ssef_pkg::COL_W-1:0] col_q, col_d;
  logic [ssef_pkg::COL_W:0]   col_sum;
  logic [ssef_pkg::OCC_W-1:0] occ_q, occ_d;
  logic                       in_acc, out_acc, clamped;
  logic [ssef_pkg::ROW_W-1:0] rd_row;

  // Stage 1: line-store data available.
  logic                                  s1_valid_q;
  logic [BPB-1:0][ssef_pkg::PIX_W-1:0]   s1_pix_q;
  ssef_pkg::side_t                       s1_side_q;
  logic [ssef_pkg::ROW_W-1:0]            s1_row_q;
  logic                                  s1_fwd_q;
  ssef_pkg::line_row_t                   s1_fwd_row_q;
  ssef_pkg::line_row_t                   ram_rdata, cur_line, wr_row;

  // Window history: the two columns left of the current word.
  ssef_pkg::col3_t [1:0]                 hist_q;
  ssef_pkg::col3_t [BPB+1:0]             cols;

  // Stages 2 and 3: gradients and magnitudes inside the lanes.
  logic                                  s2_valid_q, s3_valid_q;
  ssef_pkg::side_t                       s2_side_q, s3_side_q;
  logic [BPB-1:0][ssef_pkg::PIX_W-1:0]   lane_mag;

  // RAM port selection.
  logic                                  ram_we;
  logic [ssef_pkg::ROW_W-1:0]            ram_waddr;
  ssef_pkg::line_row_t                   ram_wdata;

  ssef_pkg::out_word_t                   out_word;

  // Configuration writes.
  always_comb begin
    line_width_d = line_width_q;
    kernel_d     = kernel_q;
    if (cfg_we_i) begin
      case (ssef_pkg::cfg_index_e'(cfg_index_i))
        ssef_pkg::CFG_LINE_WIDTH:    line_width_d = cfg_data_i;
        ssef_pkg::CFG_KERNEL_SELECT: kernel_d = ssef_pkg::kernel_e'(cfg_data_i[0]);
        default: begin
          line_width_d = line_width_q;
        end
      endcase
    end
  end

  // Handshakes and clearing pass.
  assign in_ready_o = !clr_q && (occ_q < ssef_pkg::OCC_W'(ssef_pkg::FIFO_DEPTH));
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == ssef_pkg::ROW_W'(ssef_pkg::ROWS - 1)) begin
        clr_d = 1'b0;
      end
    end
    occ_d = occ_q;
    if (in_acc && !out_acc) begin
      occ_d = occ_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      occ_d = occ_q - 1'b1;
    end
  end

  // Column advance: wraps at the effective line width or after the last word.
  assign clamped = ({1'b0, line_width_q} > (ssef_pkg::COL_W+1)'(ssef_pkg::LINE_MAX));
  assign col_sum = {1'b0, col_q} + (ssef_pkg::COL_W+1)'(BPB);
  assign rd_row  = col_q[ssef_pkg::PIX_SHIFT +: ssef_pkg::ROW_W];

  always_comb begin
    col_d = col_q;
    if (in_acc) begin
      if (in_last_i || (col_sum >= {1'b0, line_width_q}) ||
          (col_sum >= (ssef_pkg::COL_W+1)'(ssef_pkg::LINE_MAX))) begin
        col_d = '0;
      end else begin
        col_d = col_sum[ssef_pkg::COL_W-1:0];
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= ssef_pkg::LINE_WIDTH_RESET;
      kernel_q     <= ssef_pkg::KERNEL_SOBEL;
      clr_q        <= 1'b1;
      clr_cnt_q    <= '0;
      col_q        <= '0;
      occ_q        <= '0;
      s1_valid_q   <= 1'b0;
      s1_fwd_q     <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      hist_q       <= '0;
    end else begin
      line_width_q <= line_width_d;
      kernel_q     <= kernel_d;
      clr_q        <= clr_d;
      clr_cnt_q    <= clr_cnt_d;
      col_q        <= col_d;
      occ_q        <= occ_d;
      s1_valid_q   <= in_acc;
      // The word in stage 1 writes the row this word reads: forward it.
      s1_fwd_q     <= s1_valid_q && (s1_row_q == rd_row);
      s2_valid_q   <= s1_valid_q;
      s3_valid_q   <= s2_valid_q;
      if (s1_valid_q) begin
        hist_q <= cols[BPB+1:BPB];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q  <= in_pixels_i;
      s1_side_q <= '{keep: in_keep_i, strb: in_strb_i, last: in_last_i,
                     clamped: clamped};
      s1_row_q  <= rd_row;
    end
    s1_fwd_row_q <= wr_row;
    s2_side_q    <= s1_side_q;
    s3_side_q    <= s2_side_q;
  end

  // Line stores: both stores share one row so a word is one read and one write.
  assign ram_we    = clr_q || s1_valid_q;
  assign ram_waddr = clr_q ? clr_cnt_q : s1_row_q;
  assign ram_wdata = clr_q ? '0 : wr_row;

  ssef_ram #(
    .WIDTH ($bits(ssef_pkg::line_row_t)),
    .DEPTH (ssef_pkg::ROWS)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_row),
    .rdata_o (ram_rdata)
  );

  // Stage 1: window columns and line-store update.
  always_comb begin
    cur_line     = s1_fwd_q ? s1_fwd_row_q : ram_rdata;
    wr_row.older = cur_line.newer;
    wr_row.newer = s1_pix_q;
    cols[1:0]    = hist_q;
    for (int k = 0; k < BPB; k++) begin
      cols[k+2] = '{older: cur_line.older[k], newer: cur_line.newer[k],
                    current: s1_pix_q[k]};
    end
  end

  // Filter lanes, one per pixel of the word.
  for (genvar k = 0; k < BPB; k++) begin : g_lane
    ssef_lane u_lane (
      .clk_i    (clk_i),
      .kernel_i (kernel_q),
      .win_i    (cols[k+2:k]),
      .mag_o    (lane_mag[k])
    );
  end

  // Merge of lane results and output queue.
  ssef_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s3_valid_q),
    .mags_i  (lane_mag),
    .side_i  (s3_side_q),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .word_o  (out_word)
  );

  assign out_pixels_o    = out_word.pixels;
  assign out_keep_o      = out_word.side.keep;
  assign out_strb_o      = out_word.side.strb;
  assign out_last_o      = out_word.side.last;
  assign width_clamped_o = out_word.side.clamped;

endmodule

// File: dv/sobel_scharr_edge_filter_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sobel_scharr_edge_filter_tb: self-checking bench for the edge filter
// Streams pixel words through the filter under random sender bursts and
// receiver stalls. Line width and kernel are set between phases. Every
// output word is compared with a cycle-free software copy of the filter.
// ----------------------------------------------------------------------------
module sobel_scharr_edge_filter_tb;

  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int          REPORT_LIMIT  = 10;
  localparam int          PHASE_COUNT   = 12;
  localparam int          PHASE_WORDS   = 42;

  // One input word as the sender drives it.
  typedef struct packed {
    logic [ssef_pkg::WORD_W-1:0] pixels;
    logic [ssef_pkg::KEEP_W-1:0] keep;
    logic [ssef_pkg::KEEP_W-1:0] strb;
    logic                        last;
  } stream_word_t;

  // One output word as the filter should return it.
  typedef struct packed {
    logic [ssef_pkg::WORD_W-1:0] pixels;
    logic [ssef_pkg::KEEP_W-1:0] keep;
    logic [ssef_pkg::KEEP_W-1:0] strb;
    logic                        last;
    logic                        clamped;
  } edge_result_t;

  // Software copy of the filter plus the queue of words still owed by it.
  class edge_scoreboard;
    logic [ssef_pkg::PIX_W-1:0] older_line [ssef_pkg::LINE_MAX];
    logic [ssef_pkg::PIX_W-1:0] newer_line [ssef_pkg::LINE_MAX];
    logic [ssef_pkg::PIX_W-1:0] win_hist [6];
    int unsigned                col_pos;
    logic [ssef_pkg::COL_W-1:0] width_reg;
    ssef_pkg::kernel_e          kernel;
    edge_result_t               owed_q [$];
    int                         mismatches;

    function new();
      foreach (older_line[i]) older_line[i] = '0;
      foreach (newer_line[i]) newer_line[i] = '0;
      foreach (win_hist[i]) win_hist[i] = '0;
      col_pos    = 0;
      width_reg  = ssef_pkg::LINE_WIDTH_RESET;
      kernel     = ssef_pkg::KERNEL_SOBEL;
      mismatches = 0;
    endfunction

    function void write_reg(ssef_pkg::cfg_index_e idx, logic [ssef_pkg::COL_W-1:0] data);
      if (idx == ssef_pkg::CFG_LINE_WIDTH) width_reg = data;
      else kernel = ssef_pkg::kernel_e'(data[0]);
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Filter the four pixels of an accepted word and queue the result.
    function void note_word(stream_word_t w);
      edge_result_t               res;
      int unsigned                eff_width;
      int unsigned                addr;
      logic [ssef_pkg::PIX_W-1:0] col3 [3];
      logic [ssef_pkg::PIX_W-1:0] win [3][3];
      int                         corner;
      int                         middle;
      int                         gx;
      int                         gy;
      int                         mag;
      eff_width   = width_reg;
      res.clamped = 1'b0;
      if (width_reg > ssef_pkg::LINE_MAX) begin
        eff_width   = ssef_pkg::LINE_MAX;
        res.clamped = 1'b1;
      end
      corner = (kernel == ssef_pkg::KERNEL_SCHARR) ? 3 : 1;
      middle = (kernel == ssef_pkg::KERNEL_SCHARR) ? 10 : 2;
      res.pixels = '0;
      for (int px = 0; px < ssef_pkg::BYTES_PER_BEAT; px++) begin
        addr    = (col_pos + px) % ssef_pkg::LINE_MAX;
        col3[0] = older_line[addr];
        col3[1] = newer_line[addr];
        col3[2] = w.pixels[ssef_pkg::PIX_W*px +: ssef_pkg::PIX_W];
        older_line[addr] = col3[1];
        newer_line[addr] = col3[2];
        // Slide the window one column to the right.
        for (int r = 0; r < 3; r++) begin
          win[r][0]       = win_hist[2*r];
          win[r][1]       = win_hist[2*r+1];
          win[r][2]       = col3[r];
          win_hist[2*r]   = win[r][1];
          win_hist[2*r+1] = col3[r];
        end
        gx = corner * (int'(win[0][0]) - int'(win[0][2]))
           + middle * (int'(win[1][0]) - int'(win[1][2]))
           + corner * (int'(win[2][0]) - int'(win[2][2]));
        gy = corner * (int'(win[0][0]) - int'(win[2][0]))
           + middle * (int'(win[0][1]) - int'(win[2][1]))
           + corner * (int'(win[0][2]) - int'(win[2][2]));
        mag = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
        if (mag > 255) mag = 255;
        res.pixels[ssef_pkg::PIX_W*px +: ssef_pkg::PIX_W] = mag[ssef_pkg::PIX_W-1:0];
      end
      // Column advance, wrap at the line width, restart after a frame.
      col_pos += ssef_pkg::BYTES_PER_BEAT;
      if (col_pos >= eff_width) col_pos = 0;
      if (w.last) col_pos = 0;
      col_pos &= 32'hFFF;
      res.keep = w.keep;
      res.strb = w.strb;
      res.last = w.last;
      owed_q.push_back(res);
    endfunction

    // Compare a returned word with the oldest one owed.
    function void check_word(edge_result_t got);
      edge_result_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected output word pixels=%h keep=%h strb=%h last=%b clamp=%b",
                   $time, got.pixels, got.keep, got.strb, got.last, got.clamped);
        return;
      end
      want = owed_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"%0t: output mismatch, expected pixels=%h keep=%h strb=%h last=%b ",
                    "clamp=%b, got pixels=%h keep=%h strb=%h last=%b clamp=%b"},
                   $time, want.pixels, want.keep, want.strb, want.last, want.clamped,
                   got.pixels, got.keep, got.strb, got.last, got.clamped);
      end
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          cfg_we_i    = 1'b0;
  logic [0:0]                    cfg_index_i = ssef_pkg::CFG_LINE_WIDTH;
  logic [ssef_pkg::COL_W-1:0]    cfg_data_i  = '0;
  logic                          in_valid_i  = 1'b0;
  logic                          in_ready_o;
  logic [ssef_pkg::WORD_W-1:0]   in_pixels_i = '0;
  logic [ssef_pkg::KEEP_W-1:0]   in_keep_i   = '0;
  logic [ssef_pkg::KEEP_W-1:0]   in_strb_i   = '0;
  logic                          in_last_i   = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [ssef_pkg::WORD_W-1:0]   out_pixels_o;
  logic [ssef_pkg::KEEP_W-1:0]   out_keep_o;
  logic [ssef_pkg::KEEP_W-1:0]   out_strb_o;
  logic                          out_last_o;
  logic                          width_clamped_o;

  edge_scoreboard       sb = new();
  int unsigned          cycle_count = 0;
  int unsigned          scene_level = 0;
  int unsigned          stall_left  = 0;
  int unsigned          stall_mode  = 0;

  sobel_scharr_edge_filter i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .in_pixels_i     (in_pixels_i),
    .in_keep_i       (in_keep_i),
    .in_strb_i       (in_strb_i),
    .in_last_i       (in_last_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_pixels_o    (out_pixels_o),
    .out_keep_o      (out_keep_o),
    .out_strb_o      (out_strb_o),
    .out_last_o      (out_last_o),
    .width_clamped_o (width_clamped_o)
  );

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Run limit in case the filter stops moving words.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: switch at random between four stall patterns.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ((stall_left % 5) != 0);
    endcase
  end

  // Watch both channels: check returned words, record accepted ones.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_word({out_pixels_o, out_keep_o, out_strb_o, out_last_o, width_clamped_o});
      if (in_valid_i && in_ready_o)
        sb.note_word({in_pixels_i, in_keep_i, in_strb_i, in_last_i});
    end
  end

  // Write both registers on consecutive edges.
  task automatic write_config(logic [ssef_pkg::COL_W-1:0] width, ssef_pkg::kernel_e kern);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ssef_pkg::CFG_LINE_WIDTH;
    cfg_data_i  <= width;
    sb.write_reg(ssef_pkg::CFG_LINE_WIDTH, width);
    @(posedge clk_i);
    cfg_index_i <= ssef_pkg::CFG_KERNEL_SELECT;
    cfg_data_i  <= ssef_pkg::COL_W'(kern);
    sb.write_reg(ssef_pkg::CFG_KERNEL_SELECT, ssef_pkg::COL_W'(kern));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Present one word and hold it until the filter takes it.
  task automatic push_word(stream_word_t w);
    in_valid_i  <= 1'b1;
    in_pixels_i <= w.pixels;
    in_keep_i   <= w.keep;
    in_strb_i   <= w.strb;
    in_last_i   <= w.last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Wait until every owed word has come back.
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Pixel content: smooth scenes so magnitudes stay below saturation,
  // with random noise, hard steps and ramps mixed in.
  function automatic logic [ssef_pkg::WORD_W-1:0] make_pixels();
    logic [ssef_pkg::WORD_W-1:0] pix;
    int unsigned                 kind;
    int unsigned                 val;
    int unsigned                 step;
    kind = $urandom_range(0, 9);
    step = $urandom_range(0, 6);
    for (int px = 0; px < ssef_pkg::BYTES_PER_BEAT; px++) begin
      case (kind)
        0, 1, 2, 3: val = scene_level + $urandom_range(0, 3);
        4, 5:       val = scene_level + px * step;
        6, 7:       val = $urandom_range(0, 255);
        default:    val = $urandom_range(0, 1) ? 255 : 0;
      endcase
      if (val > 255) val = 255;
      pix[ssef_pkg::PIX_W*px +: ssef_pkg::PIX_W] = val[ssef_pkg::PIX_W-1:0];
    end
    return pix;
  endfunction

  // Random words in bursts with random gaps; some stretches have no gaps.
  task automatic send_random(int count);
    stream_word_t w;
    int           sent;
    int           burst;
    int           gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int i = 0; i < burst && sent < count; i++) begin
        w.pixels = make_pixels();
        w.keep   = $urandom_range(0, 15);
        w.strb   = $urandom_range(0, 15);
        w.last   = ($urandom_range(0, 19) == 0);
        push_word(w);
        sent++;
        if ($urandom_range(0, 15) == 0) scene_level = $urandom_range(0, 252);
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0 || sent == count) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Directed words: pixel extremes, mask corners, frame ends; the second
  // list runs with one word per line so the rows stack vertically.
  stream_word_t reset_words [10] = '{
    '{32'h0000_0000, 4'hF, 4'hF, 1'b0},
    '{32'hFFFF_FFFF, 4'hF, 4'hF, 1'b0},
    '{32'hFF00_FF00, 4'hF, 4'hF, 1'b0},
    '{32'h00FF_00FF, 4'h0, 4'h0, 1'b0},
    '{32'h0403_0201, 4'hF, 4'h0, 1'b0},
    '{32'h80FF_7F00, 4'h0, 4'hF, 1'b0},
    '{32'hFFFF_FFFF, 4'h5, 4'hA, 1'b0},
    '{32'h0000_0000, 4'hA, 4'h5, 1'b1},
    '{32'h1010_1010, 4'hF, 4'hF, 1'b0},
    '{32'hFFFF_FFFF, 4'hF, 4'hF, 1'b1}
  };
  stream_word_t stacked_words [10] = '{
    '{32'h0000_0000, 4'hF, 4'hF, 1'b0},
    '{32'hFFFF_FFFF, 4'hF, 4'hF, 1'b0},
    '{32'hFFFF_FFFF, 4'hF, 4'hF, 1'b0},
    '{32'h0000_0000, 4'hF, 4'hF, 1'b0},
    '{32'h0000_0000, 4'hF, 4'hF, 1'b0},
    '{32'h4040_4040, 4'hF, 4'hF, 1'b0},
    '{32'h4142_4344, 4'hF, 4'hF, 1'b0},
    '{32'h4141_4141, 4'hF, 4'hF, 1'b0},
    '{32'h4141_4141, 4'hF, 4'hF, 1'b0},
    '{32'h4141_4141, 4'hF, 4'hF, 1'b1}
  };

  // Line widths per phase: short lines for vertical structure, zero width,
  // the largest unclamped widths and clamped ones.
  int unsigned phase_width [PHASE_COUNT] = '{
    8, 16, 0, 12, 6, 4, 2048, 2049, 4095, 2047, 20, 1920
  };
  ssef_pkg::kernel_e phase_kernel [PHASE_COUNT] = '{
    ssef_pkg::KERNEL_SOBEL, ssef_pkg::KERNEL_SCHARR, ssef_pkg::KERNEL_SCHARR,
    ssef_pkg::KERNEL_SOBEL, ssef_pkg::KERNEL_SCHARR, ssef_pkg::KERNEL_SOBEL,
    ssef_pkg::KERNEL_SCHARR, ssef_pkg::KERNEL_SOBEL, ssef_pkg::KERNEL_SCHARR,
    ssef_pkg::KERNEL_SOBEL, ssef_pkg::KERNEL_SCHARR, ssef_pkg::KERNEL_SOBEL
  };

  // Main sequence: reset, directed words, then random phases.
  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (reset_words[i]) push_word(reset_words[i]);
    in_valid_i <= 1'b0;
    drain();

    write_config(ssef_pkg::COL_W'(4), ssef_pkg::KERNEL_SCHARR);
    foreach (stacked_words[i]) push_word(stacked_words[i]);
    in_valid_i <= 1'b0;
    drain();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_config(ssef_pkg::COL_W'(phase_width[p]), phase_kernel[p]);
      scene_level = $urandom_range(0, 252);
      send_random(PHASE_WORDS);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
src/ssef_pkg.sv
src/ssef_ram.sv
src/ssef_lane.sv
src/ssef_out_fifo.sv
src/sobel_scharr_edge_filter.sv
dv/sobel_scharr_edge_filter_tb.sv
